### design/rmd_pkg.sv
// Package: shared constants and types for the RSSI motion detector
`timescale 1ns / 1ps
`default_nettype none
package rmd_pkg;
    localparam int WINDOW_DEPTH_DEF  = 128;
    localparam int HISTORY_DEPTH_DEF = 10;
    localparam logic [7:0]  WINDOW_LENGTH_RST = 8'd100;
    localparam logic [11:0] SENSITIVITY_RST   = 12'd384;
    localparam logic [15:0] VARIANCE_RST      = 16'd256;
    localparam logic [15:0] THRESHOLD_RST     = 16'd333;
    localparam logic [16:0] KAL_Q             = 17'd3;
    localparam logic [17:0] KAL_R             = 18'd128;
    localparam logic [40:0] ACC_MAX           = {1'b0, {40{1'b1}}};
    localparam logic [0:0]  CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [0:0]  CFG_SENSITIVITY   = 1'b1;

    typedef struct packed {
        logic start;
        logic load_gain;
        logic kal_upd;
        logic ring_upd;
        logic div_mean;
        logic mean_done;
        logic acc_upd;
        logic sqrt_start;
        logic ewma_upd;
        logic hist_wr;
        logic sort_step;
        logic decide;
        logic out_load;
    } rmd_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic close_win;
        logic sort_done;
    } rmd_sts_t;
endpackage
`default_nettype wire

### design/rmd_if.sv
// Interfaces: request channels for samples and results
`timescale 1ns / 1ps
`default_nettype none
interface rmd_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] rssi_dbm;
    modport source (output valid, output rssi_dbm, input ready);
    modport sink (input valid, input rssi_dbm, output ready);
endinterface

interface rmd_out_if;
    logic               valid;
    logic               ready;
    logic               motion;
    logic signed [15:0] filtered_rssi;
    logic               window_done;
    logic [15:0]        window_deviation;
    logic [15:0]        motion_threshold;
    modport source (output valid, output motion, output filtered_rssi, output window_done,
                    output window_deviation, output motion_threshold, input ready);
    modport sink (input valid, input motion, input filtered_rssi, input window_done,
                  input window_deviation, input motion_threshold, output ready);
endinterface
`default_nettype wire

### design/rmd_ctrl.sv
// Controller: sequences one request through filter, window and decision steps
`timescale 1ns / 1ps
`default_nettype none
module rmd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rmd_pkg::rmd_cmd_t      cmd,
    input  wire rmd_pkg::rmd_sts_t sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_GAIN, S_KAL, S_RING, S_MEAN, S_MEANW, S_ACC, S_SQRT,
        S_EWMA, S_HIST, S_SORT, S_DECIDE, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.start      = in_valid && in_ready;
        cmd.load_gain  = (state_reg == S_GAIN) && !sts.div_busy;
        cmd.kal_upd    = (state_reg == S_KAL);
        cmd.ring_upd   = (state_reg == S_RING);
        cmd.div_mean   = (state_reg == S_MEAN);
        cmd.mean_done  = (state_reg == S_MEANW) && !sts.div_busy;
        cmd.acc_upd    = (state_reg == S_ACC);
        cmd.sqrt_start = (state_reg == S_ACC) && sts.close_win;
        cmd.ewma_upd   = (state_reg == S_SQRT) && !sts.sqrt_busy;
        cmd.hist_wr    = (state_reg == S_HIST);
        cmd.sort_step  = (state_reg == S_SORT);
        cmd.decide     = (state_reg == S_DECIDE);
        cmd.out_load   = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:   if (cmd.start) state_reg <= S_GAIN;
                S_GAIN:   if (!sts.div_busy) state_reg <= S_KAL;
                S_KAL:    state_reg <= S_RING;
                S_RING:   state_reg <= S_MEAN;
                S_MEAN:   state_reg <= S_MEANW;
                S_MEANW:  if (!sts.div_busy) state_reg <= S_ACC;
                S_ACC:    state_reg <= sts.close_win ? S_SQRT : S_OUT;
                S_SQRT:   if (!sts.sqrt_busy) state_reg <= S_HIST;
                S_EWMA:   state_reg <= S_HIST;
                S_HIST:   state_reg <= S_SORT;
                S_SORT:   if (sts.sort_done) state_reg <= S_DECIDE;
                S_DECIDE: state_reg <= S_OUT;
                S_OUT:    if (cmd.out_load) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == S_GAIN)
        else $error("accept did not start work");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("accept while busy");
endmodule
`default_nettype wire

### design/rmd_datapath.sv
// Datapath: Kalman filter, window ring, shared divider, root unit and decision
`timescale 1ns / 1ps
`default_nettype none
module rmd_datapath #(
    parameter int WINDOW_DEPTH  = rmd_pkg::WINDOW_DEPTH_DEF,
    parameter int HISTORY_DEPTH = rmd_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_idx,
    input  wire logic [11:0]       cfg_data,
    input  wire logic signed [7:0] rssi_dbm,
    input  wire rmd_pkg::rmd_cmd_t cmd,
    output rmd_pkg::rmd_sts_t      sts,
    output logic                   motion,
    output logic signed [15:0]     filtered_rssi,
    output logic                   window_done,
    output logic [15:0]            window_deviation,
    output logic [15:0]            motion_threshold
);
    localparam int WI = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LW = $clog2(WINDOW_DEPTH + 1);
    localparam int HI = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HC = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = 17 + LW;
    localparam logic [LW-1:0] LMAX = LW'(WINDOW_DEPTH);
    localparam logic [HI-1:0] HLAST = HI'(HISTORY_DEPTH - 1);
    localparam logic [HC-1:0] HFULL = HC'(HISTORY_DEPTH);

    logic [7:0]  wlen_reg;
    logic [11:0] sens_reg;
    logic signed [24:0] est_reg;
    logic [15:0] var_reg;
    logic [16:0] ppred_reg;
    logic signed [7:0] meas_reg;
    logic signed [15:0] filt_reg;
    logic [15:0] mem [WINDOW_DEPTH];
    logic [15:0] old_reg;
    logic [WI-1:0] widx_reg, idx_reg;
    logic [LW-1:0] fill_reg, len_reg;
    logic signed [SW-1:0] sum_reg;
    logic [40:0] acc_reg;
    logic [15:0] sm_reg, lastdev_reg, thr_reg;
    logic motion_reg, full_reg, done_reg;
    logic [15:0] hist [HISTORY_DEPTH];
    logic [HC-1:0] hcnt_reg;
    logic [HI-1:0] hpos_reg;
    logic [16:0] rms_reg;

    // shared restoring divider
    logic [40:0] dq_reg, dr_reg, dd_reg;
    logic [5:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [41:0] dtrial;
    // root unit
    logic [39:0] sv_reg;
    logic [19:0] sr_reg;
    logic [4:0]  scnt_reg;
    logic        sbusy_reg, spend_reg;
    // sort
    logic [15:0] srt [HISTORY_DEPTH];
    logic [HI:0] spass_reg;

    logic [LW-1:0] len_c;
    logic [WI-1:0] idx_c;
    logic signed [40:0] kal_prod;
    logic signed [24:0] kal_inc;
    logic signed [SW-1:0] sum_c;
    logic signed [17:0] mean_s;
    logic signed [18:0] dev_c;
    logic [41:0] acc_c;
    logic [HI-1:0] mid_c;
    logic [15:0] med_c;
    logic [17:0] thr_c;
    logic signed [18:0] d_c, st_c;
    logic [20:0] sterm_c;
    logic [24:0] ew_c;
    logic want_c;

    always_comb
    begin
        len_c = (wlen_reg < 8'd2) ? LW'(2) :
                ({24'd0, wlen_reg} > 32'(WINDOW_DEPTH)) ? LMAX : LW'(wlen_reg);
        idx_c = ({{(LW-WI){1'b0}}, widx_reg} >= len_c) ? '0 : widx_reg;
    end

    assign dtrial = {dr_reg[40:0], dq_reg[40]} - {1'b0, dd_reg};

    // root trial: digit by digit on remainder
    logic [21:0] sroot_rem_reg;
    logic [21:0] sroot_try;
    assign sroot_try = {sroot_rem_reg[19:0], sv_reg[39:38]} - {sr_reg, 2'b01};

    always_comb
    begin
        kal_prod = $signed({1'b0, dq_reg[15:0]}) *
                   ($signed({meas_reg, 16'd0}) - est_reg);
        kal_inc  = 25'((kal_prod + 41'sd32768) >>> 16);
        sum_c    = sum_reg - (full_reg ? $signed({{(SW-16){old_reg[15]}}, old_reg}) : '0)
                   + $signed({{(SW-16){filt_reg[15]}}, filt_reg});
        mean_s   = sum_reg[SW-1] ? -$signed({1'b0, dq_reg[16:0]})
                                 : $signed({1'b0, dq_reg[16:0]});
        dev_c    = $signed({{3{filt_reg[15]}}, filt_reg}) - $signed({mean_s[17], mean_s});
        acc_c    = {1'b0, acc_reg} + 42'(dev_c * dev_c);
        mid_c    = HI'(hcnt_reg >> 1);
        if (hcnt_reg[0])
            med_c = srt[mid_c];
        else
            med_c = 16'((17'(srt[mid_c - 1'b1]) + 17'(srt[mid_c]) + 17'd1) >> 1);
        thr_c    = (18'(med_c) * 18'd3 + 18'd1) >> 1;
        d_c      = $signed({2'b0, rms_reg}) - $signed({7'd0, sens_reg});
        sterm_c  = (21'(sens_reg) * 21'd461 + 21'd128) >> 8;
        st_c     = $signed({1'b0, (thr_c > 18'd65535) ? 18'd65535 : thr_c});
        want_c   = d_c > st_c;
        ew_c     = 25'd77 * 25'(rms_reg) + 25'd179 * 25'(sm_reg) + 25'd128;
    end

    assign sts.div_busy  = dbusy_reg;
    assign sts.sqrt_busy = sbusy_reg || spend_reg;
    assign sts.close_win = full_reg && ({{(LW-WI){1'b0}}, idx_reg} == len_c - 1'b1);
    assign sts.sort_done = (spass_reg == (HI+1)'(HISTORY_DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.ring_upd)
            mem[idx_c] <= filt_reg[15:0];
        old_reg <= mem[idx_c];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_wr)
            hist[hpos_reg] <= ew_c[23:8];
        if (cmd.sort_step)
        begin
            if (spass_reg == '0)
            begin
                for (int i = 0; i < HISTORY_DEPTH; i++)
                    srt[i] <= (HC'(i) < hcnt_reg) ? hist[i] : 16'hFFFF;
            end
            else
            begin
                for (int i = 0; i + 1 < HISTORY_DEPTH; i++)
                    if ((1'(i) == spass_reg[0]) && (srt[i] > srt[i+1]))
                    begin
                        srt[i]   <= srt[i+1];
                        srt[i+1] <= srt[i];
                    end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= rmd_pkg::WINDOW_LENGTH_RST;
            sens_reg <= rmd_pkg::SENSITIVITY_RST;
            est_reg <= '0; var_reg <= rmd_pkg::VARIANCE_RST;
            widx_reg <= '0; fill_reg <= '0; sum_reg <= '0; acc_reg <= '0;
            sm_reg <= '0; hcnt_reg <= '0; hpos_reg <= '0; lastdev_reg <= '0;
            thr_reg <= rmd_pkg::THRESHOLD_RST; motion_reg <= 1'b0;
            dbusy_reg <= 1'b0; sbusy_reg <= 1'b0; spend_reg <= 1'b0;
            spass_reg <= '0; done_reg <= 1'b0; full_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    rmd_pkg::CFG_WINDOW_LENGTH:
                    begin
                        wlen_reg <= cfg_data[7:0];
                        widx_reg <= '0; fill_reg <= '0; sum_reg <= '0; acc_reg <= '0;
                    end
                    rmd_pkg::CFG_SENSITIVITY: sens_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.start)
            begin
                meas_reg  <= rssi_dbm;
                ppred_reg <= ({1'b0, var_reg} + rmd_pkg::KAL_Q > 17'd65535) ? 17'd65535
                             : {1'b0, var_reg} + rmd_pkg::KAL_Q;
                dq_reg    <= 41'(({1'b0, var_reg} + rmd_pkg::KAL_Q > 17'd65535) ? 17'd65535
                             : {1'b0, var_reg} + rmd_pkg::KAL_Q) << 16;
                dd_reg    <= 41'((({1'b0, var_reg} + rmd_pkg::KAL_Q > 17'd65535) ? 17'd65535
                             : {1'b0, var_reg} + rmd_pkg::KAL_Q) + rmd_pkg::KAL_R);
                dr_reg    <= '0; dcnt_reg <= 6'd41; dbusy_reg <= 1'b1;
                done_reg  <= 1'b0; spass_reg <= '0;
            end
            if (dbusy_reg)
            begin
                if (!dtrial[41])
                begin
                    dr_reg <= dtrial[40:0];
                    dq_reg <= {dq_reg[39:0], 1'b1};
                end
                else
                begin
                    dr_reg <= {dr_reg[39:0], dq_reg[40]};
                    dq_reg <= {dq_reg[39:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == 6'd1) dbusy_reg <= 1'b0;
            end
            if (cmd.load_gain)
            begin
                // dq holds gain; multiply next cycle
            end
            if (cmd.kal_upd)
            begin
                est_reg <= est_reg + kal_inc;
                var_reg <= 16'((34'(17'd65536 - dq_reg[16:0]) * 34'(ppred_reg) + 34'd32768) >> 16);
                filt_reg <= ((est_reg + kal_inc + 25'sd128) >>> 8) > 25'sd32767 ? 16'sd32767
                            : 16'((est_reg + kal_inc + 25'sd128) >>> 8);
                idx_reg <= idx_c;
            end
            if (cmd.ring_upd)
            begin
                full_reg <= (fill_reg >= len_c);
                if (fill_reg >= len_c) fill_reg <= len_c;
                else fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.div_mean)
            begin
                sum_reg  <= sum_c;
                full_reg <= (fill_reg == len_c);
                widx_reg <= ({{(LW-WI){1'b0}}, idx_reg} + 1'b1 >= len_c) ? '0 : idx_reg + 1'b1;
                dq_reg   <= 41'((sum_c[SW-1] ? SW'(-sum_c) : SW'(sum_c)) + SW'(len_c >> 1));
                dd_reg   <= 41'(len_c);
                dr_reg   <= '0; dcnt_reg <= 6'd41; dbusy_reg <= 1'b1;
            end
            if (cmd.acc_upd && full_reg)
            begin
                acc_reg <= (acc_c > 42'(rmd_pkg::ACC_MAX)) ? rmd_pkg::ACC_MAX : acc_c[40:0];
                if (sts.close_win)
                begin
                    dq_reg <= (acc_c > 42'(rmd_pkg::ACC_MAX)) ? rmd_pkg::ACC_MAX : acc_c[40:0];
                    dd_reg <= 41'(len_c); dr_reg <= '0; dcnt_reg <= 6'd41;
                    dbusy_reg <= 1'b1; spend_reg <= 1'b1;
                end
            end
            if (spend_reg && !dbusy_reg)
            begin
                spend_reg <= 1'b0; sbusy_reg <= 1'b1;
                sv_reg <= dq_reg[39:0]; sr_reg <= '0; sroot_rem_reg <= '0;
                scnt_reg <= 5'd20;
            end
            if (sbusy_reg)
            begin
                if (!sroot_try[21])
                begin
                    sroot_rem_reg <= sroot_try;
                    sr_reg <= {sr_reg[18:0], 1'b1};
                end
                else
                begin
                    sroot_rem_reg <= {sroot_rem_reg[19:0], sv_reg[39:38]};
                    sr_reg <= {sr_reg[18:0], 1'b0};
                end
                sv_reg <= {sv_reg[37:0], 2'b00};
                scnt_reg <= scnt_reg - 1'b1;
                if (scnt_reg == 5'd1) sbusy_reg <= 1'b0;
            end
            if (cmd.ewma_upd)
                rms_reg <= (sr_reg > 20'd65535) ? 17'd65535 : 17'(sr_reg);
            if (cmd.hist_wr)
            begin
                sm_reg   <= ew_c[23:8];
                hpos_reg <= (hpos_reg == HLAST) ? '0 : hpos_reg + 1'b1;
                if (hcnt_reg != HFULL) hcnt_reg <= hcnt_reg + 1'b1;
            end
            if (cmd.sort_step)
                spass_reg <= spass_reg + 1'b1;
            if (cmd.decide)
            begin
                thr_reg <= st_c[15:0];
                lastdev_reg <= rms_reg[15:0];
                acc_reg <= '0; done_reg <= 1'b1;
                if (want_c != motion_reg)
                begin
                    if (want_c && d_c > st_c + $signed({1'b0, sterm_c[17:0]}))
                        motion_reg <= 1'b1;
                    else if (!want_c && d_c < st_c - $signed({1'b0, sterm_c[17:0]}))
                        motion_reg <= 1'b0;
                end
            end
            if (cmd.out_load)
            begin
                motion <= motion_reg; filtered_rssi <= filt_reg;
                window_done <= done_reg; window_deviation <= lastdev_reg;
                motion_threshold <= thr_reg;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LMAX)
        else $error("fill count beyond depth");
    a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg <= HFULL)
        else $error("history count beyond depth");
    a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(dbusy_reg && sbusy_reg))
        else $error("divider and root unit both busy");
endmodule
`default_nettype wire

### design/rssi_motion_detector_unit.sv
// Top level: RSSI motion detector, controller plus datapath
//
// Usage: one request on smp carries an 8-bit signed RSSI sample; one request on res
// returns motion flag, filtered RSSI, window flag, last RMS deviation and threshold.
// Path: a sample that does not close a window goes from accept to result through two
// passes of a 41-step restoring divider (the Kalman gain and the window mean); one
// that closes a window also takes a third divider pass, a 20-step root unit, a
// history load and HISTORY_DEPTH odd-even sort passes.
// Samples: the next sample is taken only after the previous one is done; it is taken
// while the previous result still waits in the result register.
// Configuration: cfg_we/cfg_idx/cfg_data write window_length (index 0) and
// sensitivity (index 1) while idle; a window_length write restarts the window.
// Reset: filter, window, history and motion flag return to their initial values;
// window entries and history entries are not cleared and need no clearing pass.
// Stall: while res.ready is low the result is held; a following sample is worked on
// and waits in its last step until the held result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module rssi_motion_detector_unit #(
    parameter int WINDOW_DEPTH  = rmd_pkg::WINDOW_DEPTH_DEF,
    parameter int HISTORY_DEPTH = rmd_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_idx,
    input  wire logic [11:0] cfg_data,
    rmd_in_if.sink           smp,
    rmd_out_if.source        res
);
    rmd_pkg::rmd_cmd_t cmd;
    rmd_pkg::rmd_sts_t sts;

    rmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (smp.valid),
        .in_ready  (smp.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rmd_datapath #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_idx          (cfg_idx),
        .cfg_data         (cfg_data),
        .rssi_dbm         (smp.rssi_dbm),
        .cmd              (cmd),
        .sts              (sts),
        .motion           (res.motion),
        .filtered_rssi    (res.filtered_rssi),
        .window_done      (res.window_done),
        .window_deviation (res.window_deviation),
        .motion_threshold (res.motion_threshold)
    );
endmodule
`default_nettype wire
